/* sv/tss_pkg.sv */
// Shared types, constants and byte-class functions for the SQL token splitter.
// No dependencies; used by sql_token_splitter_unit.
`default_nettype none

package tss_pkg;

  localparam int unsigned POS_BITS = 16;
  localparam logic [15:0] POS_MAX  = (POS_BITS >= 16) ? 16'hFFFF :
                                     16'((32'd1 << POS_BITS) - 32'd1);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WORD  = 2'd1;
  localparam logic [1:0] MODE_QUOTE = 2'd2;
  localparam logic [1:0] MODE_OPER  = 2'd3;

  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_QUOTED = 2'd1;
  localparam logic [1:0] KIND_OPER   = 2'd2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  typedef struct packed {
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [1:0]  tok_kind;
    logic [7:0]  escapes;
    logic        unterminated;
    logic        too_long;
    logic        run_last;
    logic        string_last;
  } tok_rec_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c <= CH_SPACE) || (c == CH_COMMA) || (c == CH_SEMI);
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == CH_SQUOTE) || (c == CH_DQUOTE);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == CH_DOLLAR) || (c == CH_PCT) || (c == CH_AMP) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_STAR) || (c == CH_PLUS) || (c == CH_MINUS) ||
           (c == CH_SLASH) || (c == CH_LT) || (c == CH_EQ) || (c == CH_GT) ||
           (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_PIPE);
  endfunction

  // length between two offsets, clipped at zero and at 16 bits
  function automatic logic [15:0] span(input logic [16:0] from_v, input logic [16:0] to_v);
    logic [16:0] d;
    d = (to_v >= from_v) ? (to_v - from_v) : 17'd0;
    return d[16] ? 16'hFFFF : d[15:0];
  endfunction

endpackage

`default_nettype wire

/* sv/tss_if.sv */
// Handshake interfaces for the byte input and token result channels.
// Does not depend on tss_pkg; all field widths are fixed here.
`default_nettype none

interface tss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface tss_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [1:0]  tok_kind;
  logic [7:0]  escapes;
  logic        unterminated;
  logic        too_long;
  logic        run_last;
  logic        string_last;
  modport source (output valid, output tok_start, output tok_len, output tok_kind,
                  output escapes, output unterminated, output too_long,
                  output run_last, output string_last, input ready);
  modport sink   (input valid, input tok_start, input tok_len, input tok_kind,
                  input escapes, input unterminated, input too_long,
                  input run_last, input string_last, output ready);
endinterface

`default_nettype wire

/* sv/sql_token_splitter_unit.sv */
// Top level of the SQL token splitter: byte scanner plus four-entry token queue.
// Depends on tss_pkg and the interfaces in tss_if.sv.
//
//   channel   dir   word                    handshake
//   in_chan   in    one string byte + last  valid/ready
//   out_chan  out   one token record        valid/ready
//
// One byte is accepted per cycle while in_chan.ready is high; the scanner state
// updates at the accept edge and the byte's zero, one or two token records enter
// the queue together. in_chan.ready is high while the queue has two free entries,
// so a byte that yields two tokens always fits; the output port sets the peak rate.
// Reset clears the scan mode, offset counters and queue pointers.
// A stalled output fills the queue and then holds off input; nothing is dropped.
`default_nettype none

module sql_token_splitter_unit (
  input  wire           clk,
  input  wire           rst_n,
  tss_in_if.sink        in_chan,
  tss_out_if.source     out_chan
);

  logic [1:0]  mode_r, mode_nxt;
  logic        qd_r, qd_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] tb_r, tb_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [7:0]  esc_r, esc_nxt;
  logic        sat_r, sat_nxt;

  tss_pkg::tok_rec_t q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;

  logic       in_acc, out_acc;
  logic [7:0] c;
  logic       lst;
  logic [16:0] cur1;
  logic       e1_v, e2_v;
  tss_pkg::tok_rec_t e1, e2, rec_a, rec_b, head;
  logic [1:0] push_n;
  logic [1:0] m1;
  logic       qd1;
  logic [15:0] tb1;
  logic [7:0]  esc1;
  logic        st_do;
  logic        oper2;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (count_r <= 3'd2);
  assign c    = in_chan.ch;
  assign lst  = in_chan.last;
  assign cur1 = {1'b0, pos_r} + 17'd1;
  assign oper2 = tss_pkg::is_oper(c) && (c != tss_pkg::CH_LPAREN) &&
                 (c != tss_pkg::CH_RPAREN) && (c != tss_pkg::CH_MINUS) &&
                 (c != tss_pkg::CH_PLUS);

  always_comb begin
    m1    = mode_r;
    qd1   = qd_r;
    tb1   = tb_r;
    esc1  = esc_r;
    st_do = 1'b0;
    e1_v  = 1'b0;
    e2_v  = 1'b0;
    e1    = '0;
    e2    = '0;
    e1.too_long = sat_r;
    e2.too_long = sat_r;

    case (mode_r)
      tss_pkg::MODE_WORD: begin
        if (tss_pkg::is_delim(c) || tss_pkg::is_oper(c)) begin
          e1_v         = 1'b1;
          e1.tok_start = tb_r;
          e1.tok_len   = tss_pkg::span({1'b0, tb_r}, {1'b0, pos_r});
          e1.tok_kind  = tss_pkg::KIND_WORD;
          st_do        = 1'b1;
        end
      end
      tss_pkg::MODE_QUOTE: begin
        if (tss_pkg::is_quote(c)) begin
          if (prev_r == tss_pkg::CH_BSLASH) begin
            if (esc_r != 8'hFF) esc1 = esc_r + 8'd1;
          end else if ((c == tss_pkg::CH_DQUOTE) == qd_r) begin
            e1_v         = 1'b1;
            e1.tok_start = tb_r;
            e1.tok_len   = tss_pkg::span({1'b0, tb_r}, {1'b0, pos_r});
            e1.tok_kind  = tss_pkg::KIND_QUOTED;
            e1.escapes   = esc_r;
            m1           = tss_pkg::MODE_IDLE;
          end
        end
      end
      tss_pkg::MODE_OPER: begin
        e1_v         = 1'b1;
        e1.tok_start = tb_r;
        e1.tok_kind  = tss_pkg::KIND_OPER;
        if (oper2) begin
          e1.tok_len = 16'd2;
          m1         = tss_pkg::MODE_IDLE;
        end else begin
          e1.tok_len = 16'd1;
          st_do      = 1'b1;
        end
      end
      default: st_do = 1'b1;
    endcase

    // start of a new token at this byte
    if (st_do) begin
      if (tss_pkg::is_delim(c)) begin
        m1 = tss_pkg::MODE_IDLE;
      end else if (tss_pkg::is_quote(c)) begin
        m1   = tss_pkg::MODE_QUOTE;
        qd1  = (c == tss_pkg::CH_DQUOTE);
        tb1  = (pos_r < tss_pkg::POS_MAX) ? cur1[15:0] : pos_r;
        esc1 = 8'd0;
      end else if (tss_pkg::is_oper(c)) begin
        m1  = tss_pkg::MODE_OPER;
        tb1 = pos_r;
      end else begin
        m1  = tss_pkg::MODE_WORD;
        tb1 = pos_r;
      end
    end

    // end of string closes any open token
    if (lst) begin
      e2.tok_start = tb1;
      case (m1)
        tss_pkg::MODE_WORD: begin
          e2_v        = 1'b1;
          e2.tok_len  = tss_pkg::span({1'b0, tb1}, cur1);
          e2.tok_kind = tss_pkg::KIND_WORD;
        end
        tss_pkg::MODE_QUOTE: begin
          e2_v            = 1'b1;
          e2.tok_len      = tss_pkg::span({1'b0, tb1}, cur1);
          e2.tok_kind     = tss_pkg::KIND_QUOTED;
          e2.escapes      = esc1;
          e2.unterminated = 1'b1;
        end
        tss_pkg::MODE_OPER: begin
          e2_v        = 1'b1;
          e2.tok_len  = 16'd1;
          e2.tok_kind = tss_pkg::KIND_OPER;
        end
        default: e2_v = 1'b0;
      endcase
      e1.string_last = 1'b1;
      e2.string_last = 1'b1;
    end
    e2.run_last = 1'b1;
    e1.run_last = !e2_v;

    rec_a  = e1_v ? e1 : e2;
    rec_b  = e2;
    push_n = in_acc ? (2'(e1_v) + 2'(e2_v)) : 2'd0;

    if (lst) begin
      mode_nxt = tss_pkg::MODE_IDLE;
      qd_nxt   = 1'b0;
      pos_nxt  = 16'd0;
      tb_nxt   = 16'd0;
      prev_nxt = 8'd0;
      esc_nxt  = 8'd0;
      sat_nxt  = 1'b0;
    end else begin
      mode_nxt = m1;
      qd_nxt   = qd1;
      tb_nxt   = tb1;
      esc_nxt  = esc1;
      prev_nxt = c;
      pos_nxt  = (pos_r < tss_pkg::POS_MAX) ? cur1[15:0] : pos_r;
      sat_nxt  = sat_r || (pos_r >= tss_pkg::POS_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tss_pkg::MODE_IDLE;
      qd_r   <= 1'b0;
      pos_r  <= 16'd0;
      tb_r   <= 16'd0;
      prev_r <= 8'd0;
      esc_r  <= 8'd0;
      sat_r  <= 1'b0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      qd_r   <= qd_nxt;
      pos_r  <= pos_nxt;
      tb_r   <= tb_nxt;
      prev_r <= prev_nxt;
      esc_r  <= esc_nxt;
      sat_r  <= sat_nxt;
    end
  end

  // token queue
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_ptr_r] <= rec_a;
    if (push_n == 2'd2) q_r[wr_ptr_r + 2'd1] <= rec_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n;
      if (out_acc) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r  <= count_r + 3'(push_n) - 3'(out_acc);
    end
  end

  assign head                  = q_r[rd_ptr_r];
  assign out_chan.valid        = (count_r != 3'd0);
  assign out_chan.tok_start    = head.tok_start;
  assign out_chan.tok_len      = head.tok_len;
  assign out_chan.tok_kind     = head.tok_kind;
  assign out_chan.escapes      = head.escapes;
  assign out_chan.unterminated = head.unterminated;
  assign out_chan.too_long     = head.too_long;
  assign out_chan.run_last     = head.run_last;
  assign out_chan.string_last  = head.string_last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("token queue overflow");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_chan.last |=> mode_r == tss_pkg::MODE_IDLE && pos_r == 16'd0 && !sat_r)
    else $error("scanner state not cleared after end of string");

  a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> pos_r == tss_pkg::POS_MAX)
    else $error("overflow flag set below position bound");

endmodule

`default_nettype wire
